[rtl/jnps_pkg.sv]
`default_nettype none

package jnps_pkg;

    localparam int DATA_W        = 32;
    localparam int GW_W          = 11;
    localparam int GH_W          = 16;
    localparam int ROW_W         = 17;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int PROD_W        = 64;
    localparam int TERM_SHIFT    = 14;
    localparam int ACC_W         = 54;
    localparam int FRAC_W        = 16;
    localparam int MAX_WIDTH_DEF = 1024;

    typedef logic signed [DATA_W-1:0] sample_t;

    localparam logic [GW_W-1:0] GRID_WIDTH_RST  = GW_W'(1024);
    localparam logic [GH_W-1:0] GRID_HEIGHT_RST = GH_W'(1024);
    localparam sample_t COEF_VERTICAL_RST       = DATA_W'(0);
    localparam sample_t COEF_HORIZONTAL_RST     = DATA_W'(0);
    localparam sample_t COEF_DIAGONAL_RST       = DATA_W'(53687091);

    localparam sample_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam sample_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH      = 3'd0,
        REG_GRID_HEIGHT     = 3'd1,
        REG_COEF_VERTICAL   = 3'd2,
        REG_COEF_HORIZONTAL = 3'd3,
        REG_COEF_DIAGONAL   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] vert;
        logic signed [DATA_W-1:0] horz;
        logic signed [DATA_W-1:0] diag;
    } coef_t;

    typedef struct packed {
        logic emit;
        logic sweep_end;
        logic wrap;
    } flags_t;

    typedef struct packed {
        sample_t [8:0] tap;
        sample_t       source;
        flags_t        flags;
    } win_item_t;

    typedef struct packed {
        sample_t phi_new;
        sample_t centre;
        flags_t  flags;
    } res_item_t;

endpackage

`default_nettype wire

[rtl/jnps_in_if.sv]
`default_nettype none

interface jnps_in_if;
    import jnps_pkg::*;

    logic    valid;
    logic    ready;
    sample_t phi_old;
    sample_t source_term;

    modport source (output valid, output phi_old, output source_term, input ready);
    modport sink (input valid, input phi_old, input source_term, output ready);
endinterface

`default_nettype wire

[rtl/jnps_out_if.sv]
`default_nettype none

interface jnps_out_if;
    import jnps_pkg::*;

    logic              valid;
    logic              ready;
    sample_t           phi_new;
    logic [DATA_W-1:0] max_change;
    logic              sweep_end;

    modport source (output valid, output phi_new, output max_change, output sweep_end,
                    input ready);
    modport sink (input valid, input phi_new, input max_change, input sweep_end,
                  output ready);
endinterface

`default_nettype wire

[rtl/jnps_cfg.sv]
`default_nettype none

module jnps_cfg #(
    parameter int MAX_WIDTH = jnps_pkg::MAX_WIDTH_DEF,
    parameter int COL_W     = $clog2(MAX_WIDTH + 2)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [jnps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jnps_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [COL_W-1:0]                 last_col,
    output logic [jnps_pkg::ROW_W-1:0]       last_row,
    output jnps_pkg::coef_t                  coef
);
    import jnps_pkg::*;

    function automatic logic [COL_W-1:0] col_limit(input logic [GW_W-1:0] gw);
        logic [31:0] wide;
        wide = 32'(gw);
        if (wide == 32'd0)
        begin
            wide = 32'd1;
        end
        else if (wide > 32'(MAX_WIDTH))
        begin
            wide = 32'(MAX_WIDTH);
        end
        return COL_W'(wide + 32'd1);
    endfunction

    function automatic logic [ROW_W-1:0] row_limit(input logic [GH_W-1:0] gh);
        logic [ROW_W-1:0] wide;
        wide = ROW_W'(gh);
        if (wide == '0)
        begin
            wide = ROW_W'(1);
        end
        return wide + ROW_W'(1);
    endfunction

    logic [COL_W-1:0] last_col_reg;
    logic [ROW_W-1:0] last_row_reg;
    coef_t            coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg  <= col_limit(GRID_WIDTH_RST);
            last_row_reg  <= row_limit(GRID_HEIGHT_RST);
            coef_reg.vert <= COEF_VERTICAL_RST;
            coef_reg.horz <= COEF_HORIZONTAL_RST;
            coef_reg.diag <= COEF_DIAGONAL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:      last_col_reg  <= col_limit(cfg_data[GW_W-1:0]);
                REG_GRID_HEIGHT:     last_row_reg  <= row_limit(cfg_data[GH_W-1:0]);
                REG_COEF_VERTICAL:   coef_reg.vert <= $signed(cfg_data[DATA_W-1:0]);
                REG_COEF_HORIZONTAL: coef_reg.horz <= $signed(cfg_data[DATA_W-1:0]);
                REG_COEF_DIAGONAL:   coef_reg.diag <= $signed(cfg_data[DATA_W-1:0]);
                default:             ;
            endcase
        end
    end

    assign last_col = last_col_reg;
    assign last_row = last_row_reg;
    assign coef     = coef_reg;

endmodule

`default_nettype wire

[rtl/jnps_front.sv]
`default_nettype none

module jnps_front #(
    parameter int MAX_WIDTH = jnps_pkg::MAX_WIDTH_DEF,
    parameter int COL_W     = $clog2(MAX_WIDTH + 2)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    jnps_in_if.sink                    stream_in,
    input  logic [COL_W-1:0]           last_col,
    input  logic [jnps_pkg::ROW_W-1:0] last_row,
    output jnps_pkg::win_item_t        win,
    output logic                       win_valid,
    input  logic                       win_ready
);
    import jnps_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH + 2;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             col_end;
    logic             row_end;
    flags_t           flags_next;
    logic             accept;
    logic             a_adv;

    sample_t upper_mem [LINE_DEPTH];
    sample_t middle_mem [LINE_DEPTH];

    logic             a_valid_reg;
    sample_t          a_sample_reg;
    sample_t          a_source_reg;
    logic [COL_W-1:0] a_col_reg;
    flags_t           a_flags_reg;
    sample_t          up_rd_reg;
    sample_t          mid_rd_reg;

    sample_t [8:0]    win_reg;
    logic             b_valid_reg;
    sample_t          b_source_reg;
    flags_t           b_flags_reg;

    always_comb
    begin
        col_end              = col_reg >= last_col;
        row_end              = row_reg >= last_row;
        flags_next.emit      = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2)) &&
                               (row_reg <= last_row) && (col_reg <= last_col);
        flags_next.sweep_end = (row_reg == last_row) && (col_reg == last_col);
        flags_next.wrap      = col_end && row_end;
        if (col_end)
        begin
            col_next = '0;
            row_next = row_end ? '0 : row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    assign a_adv           = a_valid_reg && (!b_valid_reg || win_ready);
    assign stream_in.ready = !a_valid_reg || a_adv;
    assign accept          = stream_in.valid && stream_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            win_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                a_valid_reg <= 1'b1;
            end
            else if (a_adv)
            begin
                a_valid_reg <= 1'b0;
            end

            if (a_adv)
            begin
                b_valid_reg <= a_flags_reg.emit || a_flags_reg.wrap;
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]   <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2] <= up_rd_reg;
                win_reg[5] <= mid_rd_reg;
                win_reg[8] <= a_sample_reg;
            end
            else if (win_ready)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_sample_reg <= stream_in.phi_old;
            a_source_reg <= stream_in.source_term;
            a_col_reg    <= col_reg;
            a_flags_reg  <= flags_next;
        end
        if (a_adv)
        begin
            b_source_reg <= a_source_reg;
            b_flags_reg  <= a_flags_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_rd_reg <= upper_mem[col_reg];
        end
        if (a_adv)
        begin
            upper_mem[a_col_reg] <= mid_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mid_rd_reg <= middle_mem[col_reg];
        end
        if (a_adv)
        begin
            middle_mem[a_col_reg] <= a_sample_reg;
        end
    end

    assign win.tap    = win_reg;
    assign win.source = b_source_reg;
    assign win.flags  = b_flags_reg;
    assign win_valid  = b_valid_reg;

    a_line_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && a_adv) |-> (col_reg != a_col_reg))
        else $error("line buffer read and write hit one entry in one cycle");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_W'(MAX_WIDTH + 1))
        else $error("column position beyond the line buffer");

    a_col_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && col_end) |=> (col_reg == '0))
        else $error("column position did not return to zero at row end");

endmodule

`default_nettype wire

[rtl/jnps_mac.sv]
`default_nettype none

module jnps_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  jnps_pkg::coef_t     coef,
    input  jnps_pkg::win_item_t win,
    input  logic                win_valid,
    output logic                win_ready,
    output jnps_pkg::res_item_t res,
    output logic                res_valid,
    input  logic                res_ready
);
    import jnps_pkg::*;

    localparam logic [FRAC_W-1:0] ROUND_HALF = FRAC_W'(1) << (FRAC_W - 1);
    localparam int                SAT_LSB    = DATA_W + FRAC_W - 1;

    function automatic logic signed [ACC_W-1:0] term(input logic signed [PROD_W-1:0] p);
        return ACC_W'(p >>> TERM_SHIFT);
    endfunction

    logic p_load;
    logic s_load;
    logic q_load;
    logic r_load;

    logic                     p_valid_reg;
    logic signed [PROD_W-1:0] prod_reg [8];
    sample_t                  p_source_reg;
    sample_t                  p_centre_reg;
    flags_t                   p_flags_reg;

    logic                     s_valid_reg;
    logic signed [ACC_W-1:0]  pair_reg [4];
    logic signed [ACC_W-1:0]  dterm_reg;
    sample_t                  s_centre_reg;
    flags_t                   s_flags_reg;

    logic                     q_valid_reg;
    logic signed [ACC_W-1:0]  q_reg [2];
    sample_t                  q_centre_reg;
    flags_t                   q_flags_reg;

    logic                     r_valid_reg;
    sample_t                  r_phi_reg;
    sample_t                  r_centre_reg;
    flags_t                   r_flags_reg;

    logic signed [ACC_W-1:0]  acc;
    logic [ACC_W-SAT_LSB-1:0] acc_top;
    sample_t                  phi_sat;

    assign r_load    = !r_valid_reg || res_ready;
    assign q_load    = !q_valid_reg || r_load;
    assign s_load    = !s_valid_reg || q_load;
    assign p_load    = !p_valid_reg || s_load;
    assign win_ready = p_load;

    always_comb
    begin
        acc     = q_reg[0] + q_reg[1];
        acc_top = acc[ACC_W-1:SAT_LSB];
        if ((&acc_top) || !(|acc_top))
        begin
            phi_sat = acc[DATA_W+FRAC_W-1:FRAC_W];
        end
        else
        begin
            phi_sat = acc[ACC_W-1] ? DATA_MIN : DATA_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_load)
            begin
                p_valid_reg <= win_valid;
            end
            if (s_load)
            begin
                s_valid_reg <= p_valid_reg;
            end
            if (q_load)
            begin
                q_valid_reg <= s_valid_reg;
            end
            if (r_load)
            begin
                r_valid_reg <= q_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_load)
        begin
            prod_reg[0]  <= coef.vert * win.tap[1];
            prod_reg[1]  <= coef.vert * win.tap[7];
            prod_reg[2]  <= coef.horz * win.tap[3];
            prod_reg[3]  <= coef.horz * win.tap[5];
            prod_reg[4]  <= coef.diag * win.tap[0];
            prod_reg[5]  <= coef.diag * win.tap[2];
            prod_reg[6]  <= coef.diag * win.tap[6];
            prod_reg[7]  <= coef.diag * win.tap[8];
            p_source_reg <= win.source;
            p_centre_reg <= win.tap[4];
            p_flags_reg  <= win.flags;
        end
        if (s_load)
        begin
            pair_reg[0]  <= term(prod_reg[0]) + term(prod_reg[1]);
            pair_reg[1]  <= term(prod_reg[2]) + term(prod_reg[3]);
            pair_reg[2]  <= term(prod_reg[4]) + term(prod_reg[5]);
            pair_reg[3]  <= term(prod_reg[6]) + term(prod_reg[7]);
            dterm_reg    <= $signed({{(ACC_W-DATA_W-FRAC_W){p_source_reg[DATA_W-1]}},
                                     p_source_reg, ROUND_HALF});
            s_centre_reg <= p_centre_reg;
            s_flags_reg  <= p_flags_reg;
        end
        if (q_load)
        begin
            q_reg[0]     <= pair_reg[0] + pair_reg[1];
            q_reg[1]     <= pair_reg[2] + pair_reg[3] + dterm_reg;
            q_centre_reg <= s_centre_reg;
            q_flags_reg  <= s_flags_reg;
        end
        if (r_load)
        begin
            r_phi_reg    <= phi_sat;
            r_centre_reg <= q_centre_reg;
            r_flags_reg  <= q_flags_reg;
        end
    end

    assign res.phi_new = r_phi_reg;
    assign res.centre  = r_centre_reg;
    assign res.flags   = r_flags_reg;
    assign res_valid   = r_valid_reg;

endmodule

`default_nettype wire

[rtl/jnps_track.sv]
`default_nettype none

module jnps_track (
    input  logic                clk,
    input  logic                rst_n,
    input  jnps_pkg::res_item_t res,
    input  logic                res_valid,
    output logic                res_ready,
    jnps_out_if.source          stream_out
);
    import jnps_pkg::*;

    logic                    m_load;
    logic                    o_load;
    logic signed [DATA_W:0]  diff;
    logic        [DATA_W:0]  diff_abs;
    logic        [DATA_W-1:0] max_next;

    logic                    m_valid_reg;
    logic        [DATA_W-1:0] m_mag_reg;
    sample_t                 m_phi_reg;
    flags_t                  m_flags_reg;

    logic                    o_valid_reg;
    sample_t                 o_phi_reg;
    logic        [DATA_W-1:0] o_max_reg;
    logic                    o_end_reg;
    logic        [DATA_W-1:0] largest_reg;

    assign o_load    = !o_valid_reg || stream_out.ready;
    assign m_load    = !m_valid_reg || o_load;
    assign res_ready = m_load;

    always_comb
    begin
        diff     = $signed({res.centre[DATA_W-1], res.centre}) -
                   $signed({res.phi_new[DATA_W-1], res.phi_new});
        diff_abs = diff[DATA_W] ? (DATA_W+1)'(0) - diff : diff;
        max_next = largest_reg;
        if (m_flags_reg.emit && (m_mag_reg > largest_reg))
        begin
            max_next = m_mag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            largest_reg <= '0;
        end
        else
        begin
            if (m_load)
            begin
                m_valid_reg <= res_valid;
            end
            if (o_load)
            begin
                o_valid_reg <= m_valid_reg && m_flags_reg.emit;
                if (m_valid_reg)
                begin
                    largest_reg <= m_flags_reg.wrap ? '0 : max_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_load)
        begin
            m_mag_reg   <= diff_abs[DATA_W-1:0];
            m_phi_reg   <= res.phi_new;
            m_flags_reg <= res.flags;
        end
        if (o_load)
        begin
            o_phi_reg <= m_phi_reg;
            o_max_reg <= m_flags_reg.sweep_end ? max_next : '0;
            o_end_reg <= m_flags_reg.sweep_end;
        end
    end

    assign stream_out.valid      = o_valid_reg;
    assign stream_out.phi_new    = o_phi_reg;
    assign stream_out.max_change = o_max_reg;
    assign stream_out.sweep_end  = o_end_reg;

    a_wrap_clears_max: assert property (@(posedge clk) disable iff (!rst_n)
        (o_load && m_valid_reg && m_flags_reg.wrap) |=> (largest_reg == '0))
        else $error("running maximum not cleared at sweep wrap");

endmodule

`default_nettype wire

[rtl/jacobi_nine_point_stencil_sweep.sv]
// Channel      Dir  Handshake      Payload
// stream_in    in   valid/ready    phi_old, source_term (one padded grid sample)
// stream_out   out  valid/ready    phi_new, max_change, sweep_end (one interior centre)
// cfg          in   cfg_we         cfg_index, cfg_data (write only)
//
// One sample is taken every cycle while ready; it passes stages a, b, p, s, q, r, m, o.
// The rate is set by the single read port and single write port of each line buffer.
// Reset clears position, window and running maximum; line buffers are not cleared.
// Padding samples leave no result; stream_in.ready drops only when every stage is
// full and stream_out is stalled.
`default_nettype none

module jacobi_nine_point_stencil_sweep #(
    parameter int MAX_WIDTH = jnps_pkg::MAX_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [jnps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jnps_pkg::CFG_DATA_W-1:0] cfg_data,
    jnps_in_if.sink                         stream_in,
    jnps_out_if.source                      stream_out
);
    import jnps_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH + 2);

    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;
    coef_t            coef;
    win_item_t        win;
    logic             win_valid;
    logic             win_ready;
    res_item_t        res;
    logic             res_valid;
    logic             res_ready;

    jnps_cfg #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .last_col  (last_col),
        .last_row  (last_row),
        .coef      (coef)
    );

    jnps_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream_in (stream_in),
        .last_col  (last_col),
        .last_row  (last_row),
        .win       (win),
        .win_valid (win_valid),
        .win_ready (win_ready)
    );

    jnps_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef),
        .win       (win),
        .win_valid (win_valid),
        .win_ready (win_ready),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

    jnps_track u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .res        (res),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .stream_out (stream_out)
    );

endmodule

`default_nettype wire

[verif/stencil_checker.sv]
`timescale 1ns / 1ps

module stencil_checker
    import jnps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    jnps_in_if                    in_ch,
    jnps_out_if                   out_ch,
    output int                    fail_count,
    output int                    pending,
    output logic                  at_origin
);

    localparam int LINE_DEPTH = MAX_WIDTH_DEF + 2;
    localparam int REPORT_CAP = 100;

    typedef struct packed {
        sample_t           phi_new;
        logic [DATA_W-1:0] max_change;
        logic              sweep_end;
    } centre_result_t;

    logic [GW_W-1:0]   width_reg;
    logic [GH_W-1:0]   height_reg;
    sample_t           vert_weight;
    sample_t           horz_weight;
    sample_t           diag_weight;
    sample_t           upper_row [LINE_DEPTH];
    sample_t           middle_row [LINE_DEPTH];
    sample_t           taps [9];
    int                col_pos;
    int                row_pos;
    logic [DATA_W-1:0] peak_change;
    centre_result_t    centre_queue [$];

    assign at_origin = (col_pos == 0) && (row_pos == 0);

    task automatic report_mismatch(input string what, input logic [31:0] seen,
                                   input logic [31:0] wanted);
        if (fail_count < REPORT_CAP)
            $display("%0t mismatch on %s: got %h, want %h", $time, what, seen, wanted);
        fail_count++;
    endtask

    function automatic longint weighted(input sample_t weight, input sample_t tap);
        longint product;
        product = longint'(weight) * longint'(tap);
        return product >>> TERM_SHIFT;
    endfunction

    function automatic bit advance_centre(input sample_t phi, input sample_t src,
                                          output centre_result_t res);
        int      last_col;
        int      last_row;
        int      addr;
        longint  acc;
        longint  rounded;
        longint  gap;
        sample_t up_tap;
        sample_t mid_tap;
        bit      emit;

        if (width_reg == 0)
            last_col = 2;
        else if (width_reg > MAX_WIDTH_DEF)
            last_col = MAX_WIDTH_DEF + 1;
        else
            last_col = int'(width_reg) + 1;
        last_row = (height_reg == 0) ? 2 : int'(height_reg) + 1;

        addr = (col_pos > LINE_DEPTH - 1) ? LINE_DEPTH - 1 : col_pos;
        up_tap = upper_row[addr];
        mid_tap = middle_row[addr];
        upper_row[addr] = mid_tap;
        middle_row[addr] = phi;

        for (int k = 0; k < 3; k++)
        begin
            taps[3*k] = taps[3*k+1];
            taps[3*k+1] = taps[3*k+2];
        end
        taps[2] = up_tap;
        taps[5] = mid_tap;
        taps[8] = phi;

        emit = (row_pos >= 2) && (col_pos >= 2) && (row_pos <= last_row) &&
               (col_pos <= last_col);
        res = '0;
        if (emit)
        begin
            acc = weighted(vert_weight, taps[1]) + weighted(vert_weight, taps[7])
                + weighted(horz_weight, taps[3]) + weighted(horz_weight, taps[5])
                + weighted(diag_weight, taps[0]) + weighted(diag_weight, taps[2])
                + weighted(diag_weight, taps[6]) + weighted(diag_weight, taps[8])
                + (longint'(src) <<< FRAC_W);
            rounded = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
            if (rounded > longint'(DATA_MAX))
                rounded = longint'(DATA_MAX);
            if (rounded < longint'(DATA_MIN))
                rounded = longint'(DATA_MIN);

            gap = longint'(taps[4]) - rounded;
            if (gap < 0)
                gap = -gap;
            if (gap > longint'(32'hFFFF_FFFF))
                gap = longint'(32'hFFFF_FFFF);
            if (gap[31:0] > peak_change)
                peak_change = gap[31:0];

            res.phi_new = rounded[31:0];
            res.sweep_end = (row_pos == last_row) && (col_pos == last_col);
            res.max_change = res.sweep_end ? peak_change : '0;
        end

        if (col_pos >= last_col)
        begin
            col_pos = 0;
            if (row_pos >= last_row)
            begin
                row_pos = 0;
                peak_change = '0;
            end
            else
            begin
                row_pos++;
            end
        end
        else
        begin
            col_pos++;
        end
        return emit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        centre_result_t want;
        centre_result_t fresh;

        if (!rst_n)
        begin
            width_reg = GRID_WIDTH_RST;
            height_reg = GRID_HEIGHT_RST;
            vert_weight = COEF_VERTICAL_RST;
            horz_weight = COEF_HORIZONTAL_RST;
            diag_weight = COEF_DIAGONAL_RST;
            for (int i = 0; i < LINE_DEPTH; i++)
            begin
                upper_row[i] = '0;
                middle_row[i] = '0;
            end
            for (int i = 0; i < 9; i++)
                taps[i] = '0;
            col_pos = 0;
            row_pos = 0;
            peak_change = '0;
            centre_queue.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_GRID_WIDTH:      width_reg = cfg_data[GW_W-1:0];
                    REG_GRID_HEIGHT:     height_reg = cfg_data[GH_W-1:0];
                    REG_COEF_VERTICAL:   vert_weight = cfg_data;
                    REG_COEF_HORIZONTAL: horz_weight = cfg_data;
                    REG_COEF_DIAGONAL:   diag_weight = cfg_data;
                    default: ;
                endcase
            end

            if (out_ch.valid && out_ch.ready)
            begin
                if (centre_queue.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected", out_ch.phi_new, 'x);
                end
                else
                begin
                    want = centre_queue.pop_front();
                    if (out_ch.phi_new !== want.phi_new)
                        report_mismatch("phi_new", out_ch.phi_new, want.phi_new);
                    if (out_ch.max_change !== want.max_change)
                        report_mismatch("max_change", out_ch.max_change, want.max_change);
                    if (out_ch.sweep_end !== want.sweep_end)
                        report_mismatch("sweep_end", 32'(out_ch.sweep_end),
                                        32'(want.sweep_end));
                end
            end

            if (in_ch.valid && in_ch.ready)
            begin
                if (advance_centre(in_ch.phi_old, in_ch.source_term, fresh))
                    centre_queue.push_back(fresh);
            end

            pending = centre_queue.size();
        end
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import jnps_pkg::*;

    localparam int     DRAIN_CYCLES   = 16;
    localparam int     RANDOM_SAMPLES = 800;
    localparam longint LIMIT_NS       = 12_000_000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    steady;
    int                    fed_count;
    int                    fail_count;
    int                    pending;
    logic                  at_origin;

    jnps_in_if  in_ch ();
    jnps_out_if out_ch ();

    jacobi_nine_point_stencil_sweep u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .stream_in  (in_ch),
        .stream_out (out_ch)
    );

    stencil_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .at_origin  (at_origin)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= steady || ($urandom_range(99) >= 26);
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("FAIL jacobi_nine_point_stencil_sweep");
        $finish;
    end

    function automatic sample_t pick_value();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(9))
            0:       return DATA_MAX;
            1:       return DATA_MIN;
            2, 3:    return {{12{v[19]}}, v[19:0]};
            default: return v;
        endcase
    endfunction

    function automatic sample_t pick_weight();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(7))
            0:       return DATA_MAX;
            1:       return DATA_MIN;
            2:       return '0;
            3, 4:    return {{5{v[26]}}, v[26:0]};
            5:       return {{2{v[29]}}, v[29:0]};
            default: return v;
        endcase
    endfunction

    task automatic send_sample(input sample_t phi, input sample_t src);
        while (!steady && $urandom_range(99) < 26)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.phi_old <= phi;
        in_ch.source_term <= src;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        fed_count++;
    endtask

    // hold the input quiet until every centre is back and the pipe is empty
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] cols, input logic [31:0] rows,
                             input sample_t vert, input sample_t horz, input sample_t diag);
        settle();
        write_reg(REG_GRID_WIDTH, cols);
        write_reg(REG_GRID_HEIGHT, rows);
        write_reg(REG_COEF_VERTICAL, vert);
        write_reg(REG_COEF_HORIZONTAL, horz);
        write_reg(REG_COEF_DIAGONAL, diag);
    endtask

    task automatic feed_rest();
        do
            send_sample(pick_value(), pick_value());
        while (!at_origin);
    endtask

    task automatic corner_sweep(input int cols, input int rows, input sample_t vert,
                                input sample_t horz, input sample_t diag, input sample_t rim,
                                input sample_t centre, input sample_t src);
        configure(cols, rows, vert, horz, diag);
        for (int i = 0; i < 9; i++)
            send_sample((i == 4) ? centre : rim, src);
    endtask

    initial
    begin
        int cols;
        int span;
        int start_count;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_GRID_WIDTH;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.phi_old = '0;
        in_ch.source_term = '0;
        steady = 1'b0;
        fed_count = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // part of the first row on the reset geometry, then narrow and cut the sweep short
        repeat ($urandom_range(12, 40)) send_sample(pick_value(), pick_value());
        settle();
        write_reg(REG_GRID_WIDTH, 32'd2);
        write_reg(REG_GRID_HEIGHT, 32'd1);
        feed_rest();

        corner_sweep(0, 0, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MIN, DATA_MAX);
        corner_sweep(1, 1, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MAX, DATA_MAX, DATA_MIN);
        corner_sweep(1, 1, 268435456, -1, 1, -1, 7, 5);

        // widest row, no idling on either side, narrowed part way through its first row
        configure(2047, 0, pick_weight(), pick_weight(), pick_weight());
        steady = 1'b1;
        repeat ($urandom_range(100, 200)) send_sample(pick_value(), pick_value());
        settle();
        write_reg(REG_GRID_WIDTH, 32'd1);
        feed_rest();
        steady = 1'b0;

        // tallest frame, ended early by a height drop
        configure(1, 65535, pick_weight(), pick_weight(), pick_weight());
        repeat ($urandom_range(12, 30)) send_sample(pick_value(), pick_value());
        settle();
        write_reg(REG_GRID_HEIGHT, $urandom_range(0, 2));
        feed_rest();

        cols = 1;
        start_count = fed_count;
        while (fed_count - start_count < RANDOM_SAMPLES)
        begin
            if ($urandom_range(3) != 0)
            begin
                cols = ($urandom_range(7) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 5);
                configure(($urandom & 32'hFFFF_F800) | cols,
                          ($urandom & 32'hFFFF_0000) | $urandom_range(0, 5),
                          pick_weight(), pick_weight(), pick_weight());
                if (cols == 0)
                    cols = 1;
            end
            // narrow the grid or move its bottom part way through a sweep
            if ($urandom_range(4) == 0)
            begin
                span = $urandom_range(1, 40);
                do
                begin
                    send_sample(pick_value(), pick_value());
                    span--;
                end
                while (span > 0 && !at_origin);
                if (!at_origin)
                begin
                    settle();
                    cols = $urandom_range(0, cols);
                    write_reg(REG_GRID_WIDTH, cols);
                    write_reg(REG_GRID_HEIGHT, $urandom_range(0, 8));
                    if (cols == 0)
                        cols = 1;
                end
            end
            feed_rest();
        end

        settle();
        if (fail_count == 0)
            $display("PASS jacobi_nine_point_stencil_sweep");
        else
            $display("FAIL jacobi_nine_point_stencil_sweep");
        $finish;
    end

endmodule

[sim.f]
rtl/jnps_pkg.sv
rtl/jnps_in_if.sv
rtl/jnps_out_if.sv
rtl/jnps_cfg.sv
rtl/jnps_front.sv
rtl/jnps_mac.sv
rtl/jnps_track.sv
rtl/jacobi_nine_point_stencil_sweep.sv
verif/stencil_checker.sv
verif/testbench.sv
